### hw/rtl/symbolic_mode_parser_defines.svh
// Assertion macros shared by the mode parser RTL.
// Self-contained; included by the files that carry assertions.
`ifndef SYMBOLIC_MODE_PARSER_DEFINES_SVH
`define SYMBOLIC_MODE_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SMP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/smp_pkg.sv
// Shared constants for the symbolic mode parser: widths, character codes,
// permission masks and the register map. No dependencies.
package smp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MODE_W  = 12;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register map: paddr[2] selects the register word
  localparam logic REG_UMASK = 1'b0;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_XU    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
  localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
  localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h74;
  localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
  localparam logic [CHAR_W-1:0] CH_W     = 8'h77;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

  // '0'..'7' share these upper bits
  localparam logic [CHAR_W-4:0] OCT_DIGIT_HI = 5'b00110;

  localparam logic [MODE_W-1:0] MODE_MAX   = 12'o7777;
  localparam logic [MODE_W-1:0] WHO_KEEP   = 12'o1000;
  localparam logic [MODE_W-1:0] WHO_U      = 12'o4700;
  localparam logic [MODE_W-1:0] WHO_G      = 12'o2070;
  localparam logic [MODE_W-1:0] WHO_O      = 12'o0007;
  localparam logic [MODE_W-1:0] WHO_A      = 12'o6777;
  localparam logic [MODE_W-1:0] PERM_ID    = 12'o6000;
  localparam logic [MODE_W-1:0] PERM_R     = 12'o0444;
  localparam logic [MODE_W-1:0] PERM_W     = 12'o0222;
  localparam logic [MODE_W-1:0] PERM_X     = 12'o0111;
  localparam logic [MODE_W-1:0] PERM_RWX   = 12'o0777;

endpackage

### hw/rtl/smp_in_if.sv
// Input channel of the mode parser: one string character per transfer.
// Depends on smp_pkg.
interface smp_in_if;
  logic                             valid;
  logic                             ready;
  logic [smp_pkg::CHAR_W-1:0]       character;
  logic [smp_pkg::MODE_W-1:0]       start_mode;
  logic                             is_dir;

  modport source (output valid, output character, output start_mode, output is_dir,
                  input ready);
  modport sink   (input valid, input character, input start_mode, input is_dir,
                  output ready);
endinterface

### hw/rtl/smp_out_if.sv
// Result channel of the mode parser: one mode per terminated string.
// Depends on smp_pkg.
interface smp_out_if;
  logic                             valid;
  logic                             ready;
  logic [smp_pkg::MODE_W-1:0]       new_mode;
  logic                             invalid;

  modport source (output valid, output new_mode, output invalid, input ready);
  modport sink   (input valid, input new_mode, input invalid, output ready);
endinterface

### hw/rtl/symbolic_mode_parser.sv
// Top level of the permission-mode string parser.
// Depends on smp_pkg, smp_in_if, smp_out_if, smp_cfg and smp_parser.
//
// Feed a mode string one character per transfer, ended by a NUL; start_mode and
// is_dir are sampled with the first character. The string is either all octal
// digits (above 07777 it saturates to 07777 and is flagged invalid) or a list of
// comma-separated symbolic clauses. Each NUL yields one result (new_mode,
// invalid) and the parser returns to string start. One character is accepted per
// cycle while the input is not stalled, and a result appears on the output in the
// cycle after its NUL is taken, held in an output register. While
// that register holds a result the sink has not taken, a character is accepted
// only in a cycle in which the sink takes the result, so a stalled sink stalls
// the input. Write the umask register (APB address 0) only while no string is in
// progress.
module symbolic_mode_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  smp_in_if.sink                        in_i,
  smp_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smp_pkg::PADDR_W-1:0]   paddr,
  input  logic [smp_pkg::PDATA_W-1:0]   pwdata,
  output logic [smp_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [smp_pkg::MODE_W-1:0] umask;

  smp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .umask_o (umask)
  );

  smp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .umask_i (umask),
    .in_if   (in_i),
    .out_if  (out_o)
  );

endmodule

### hw/rtl/smp_cfg.sv
// APB register file of the mode parser (umask register).
// Depends on smp_pkg.
module smp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smp_pkg::PADDR_W-1:0]   paddr,
  input  logic [smp_pkg::PDATA_W-1:0]   pwdata,
  output logic [smp_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [smp_pkg::MODE_W-1:0]    umask_o
);

  logic [smp_pkg::MODE_W-1:0] umask_q;
  logic                       umask_sel;
  logic                       wr_en;

  assign pready    = 1'b1;
  assign umask_sel = (paddr[2] == smp_pkg::REG_UMASK);
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      umask_q <= '0;
    end else if (wr_en && umask_sel) begin
      umask_q <= pwdata[smp_pkg::MODE_W-1:0];
    end
  end

  assign prdata  = umask_sel ? {{(smp_pkg::PDATA_W-smp_pkg::MODE_W){1'b0}}, umask_q} : '0;
  assign umask_o = umask_q;

endmodule

### hw/rtl/smp_parser.sv
// Character-at-a-time parser: parse state registers, next-state logic and
// the result register. Depends on smp_pkg, smp_in_if, smp_out_if and the defines header.
`include "symbolic_mode_parser_defines.svh"

module smp_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [smp_pkg::MODE_W-1:0]  umask_i,
  smp_in_if.sink                      in_if,
  smp_out_if.source                   out_if
);

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_OCTAL   = 3'd1,
    PH_WHO     = 3'd2,
    PH_OPSTART = 3'd3,
    PH_PERMS   = 3'd4,
    PH_AFTER   = 3'd5,
    PH_ERROR   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_SET = 2'd2
  } op_e;

  function automatic logic [smp_pkg::MODE_W-1:0] apply_op(
    input logic [smp_pkg::MODE_W-1:0] mode,
    input logic [smp_pkg::MODE_W-1:0] who,
    input logic [smp_pkg::MODE_W-1:0] opnd,
    input op_e                        op
  );
    logic [smp_pkg::MODE_W-1:0] sel;
    sel = opnd & who;
    case (op)
      OP_ADD:  apply_op = mode | sel;
      OP_SUB:  apply_op = mode & ~sel;
      default: apply_op = (mode & ~who) | sel;
    endcase
  endfunction

  phase_e                       phase_q, phase_d;
  logic [smp_pkg::MODE_W-1:0]   mode_q, mode_d;
  logic [smp_pkg::MODE_W-1:0]   who_q, who_d;
  op_e                          op_q, op_d;
  logic [smp_pkg::MODE_W-1:0]   opnd_q, opnd_d;
  logic [smp_pkg::MODE_W-1:0]   oct_q, oct_d;
  logic                         err_q, err_d;
  logic                         dir_q, dir_d;

  logic                         out_valid_q;
  logic [smp_pkg::MODE_W-1:0]   out_mode_q;
  logic                         out_inv_q;

  logic                         emit;
  logic [smp_pkg::MODE_W-1:0]   emit_mode;
  logic                         emit_inv;
  logic                         done;
  logic                         handled;
  logic                         is_op;
  op_e                          char_op;
  logic [smp_pkg::MODE_W+2:0]   oct_next;
  logic [2:0]                   copy_t;
  logic [smp_pkg::CHAR_W-1:0]   c;
  logic                         c_octal;
  logic                         accept;

  assign c       = in_if.character;
  assign c_octal = (c[smp_pkg::CHAR_W-1:3] == smp_pkg::OCT_DIGIT_HI);

  always_comb begin
    is_op   = 1'b1;
    char_op = OP_ADD;
    case (c)
      smp_pkg::CH_PLUS:  char_op = OP_ADD;
      smp_pkg::CH_MINUS: char_op = OP_SUB;
      smp_pkg::CH_EQ:    char_op = OP_SET;
      default:           is_op   = 1'b0;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    mode_d    = mode_q;
    who_d     = who_q;
    op_d      = op_q;
    opnd_d    = opnd_q;
    oct_d     = oct_q;
    err_d     = err_q;
    dir_d     = dir_q;
    emit      = 1'b0;
    emit_mode = '0;
    emit_inv  = 1'b0;
    done      = 1'b0;
    handled   = 1'b0;
    oct_next  = {oct_q, c[2:0]};
    copy_t    = mode_q[2:0];

    // First character of a string: load the start state, then fall through
    if (phase_q == PH_START) begin
      mode_d = in_if.start_mode;
      dir_d  = in_if.is_dir;
      err_d  = 1'b0;
      oct_d  = '0;
      who_d  = smp_pkg::WHO_KEEP;
      op_d   = OP_ADD;
      opnd_d = '0;
      if (c == smp_pkg::CH_NUL) begin
        emit     = 1'b1;
        emit_inv = 1'b1;
        done     = 1'b1;
      end else if (c_octal) begin
        oct_d   = {{(smp_pkg::MODE_W-3){1'b0}}, c[2:0]};
        phase_d = PH_OCTAL;
        done    = 1'b1;
      end else begin
        phase_d = PH_WHO;
      end
    end

    if (!done) begin
      case (phase_d)
        PH_OCTAL: begin
          if (c == smp_pkg::CH_NUL) begin
            emit      = 1'b1;
            emit_mode = err_q ? smp_pkg::MODE_MAX : oct_q;
            emit_inv  = err_q;
          end else if (c_octal) begin
            if (err_q || (oct_next[smp_pkg::MODE_W+2:smp_pkg::MODE_W] != 3'b000)) begin
              err_d = 1'b1;
              oct_d = smp_pkg::MODE_MAX;
            end else begin
              oct_d = oct_next[smp_pkg::MODE_W-1:0];
            end
          end else begin
            err_d   = 1'b1;
            phase_d = PH_ERROR;
          end
        end

        PH_WHO: begin
          if (c == smp_pkg::CH_U) begin
            who_d = who_d | smp_pkg::WHO_U;
          end else if (c == smp_pkg::CH_G) begin
            who_d = who_d | smp_pkg::WHO_G;
          end else if (c == smp_pkg::CH_O) begin
            who_d = who_d | smp_pkg::WHO_O;
          end else if (c == smp_pkg::CH_A) begin
            who_d = who_d | smp_pkg::WHO_A;
          end else if (is_op) begin
            // no who letters: all classes less the umask
            if ((who_d & smp_pkg::PERM_RWX) == '0) begin
              who_d = who_d | (smp_pkg::WHO_A & ~umask_i);
            end
            op_d    = char_op;
            opnd_d  = '0;
            phase_d = PH_OPSTART;
          end else if (c == smp_pkg::CH_NUL) begin
            emit     = 1'b1;
            emit_inv = 1'b1;
          end else begin
            err_d   = 1'b1;
            phase_d = PH_ERROR;
          end
        end

        PH_OPSTART, PH_PERMS, PH_AFTER: begin
          if (phase_d == PH_OPSTART &&
              (c == smp_pkg::CH_U || c == smp_pkg::CH_G || c == smp_pkg::CH_O)) begin
            // copy from one class: one letter only, drops the keep bit for the clause
            case (c)
              smp_pkg::CH_U: copy_t = mode_q[8:6];
              smp_pkg::CH_G: copy_t = mode_q[5:3];
              default:       copy_t = mode_q[2:0];
            endcase
            opnd_d = {3'b000, copy_t, copy_t, copy_t};
            if ((c == smp_pkg::CH_U && mode_q[11]) || (c == smp_pkg::CH_G && mode_q[10])) begin
              opnd_d = opnd_d | smp_pkg::PERM_ID;
            end
            who_d   = who_q & ~smp_pkg::WHO_KEEP;
            mode_d  = apply_op(mode_q, who_d, opnd_d, op_q);
            phase_d = PH_AFTER;
            handled = 1'b1;
          end
          if (!handled && phase_d != PH_AFTER) begin
            handled = 1'b1;
            case (c)
              smp_pkg::CH_R: opnd_d = opnd_q | smp_pkg::PERM_R;
              smp_pkg::CH_W: opnd_d = opnd_q | smp_pkg::PERM_W;
              smp_pkg::CH_X: opnd_d = opnd_q | smp_pkg::PERM_X;
              smp_pkg::CH_XU: begin
                if (dir_q || ((mode_q & smp_pkg::PERM_X) != '0)) begin
                  opnd_d = opnd_q | smp_pkg::PERM_X;
                end
              end
              smp_pkg::CH_S: opnd_d = opnd_q | smp_pkg::PERM_ID;
              smp_pkg::CH_T: opnd_d = opnd_q;
              default:       handled = 1'b0;
            endcase
            if (handled) begin
              phase_d = PH_PERMS;
            end else begin
              mode_d = apply_op(mode_q, who_q, opnd_q, op_q);
            end
          end
          if (!handled) begin
            if (is_op) begin
              op_d    = char_op;
              opnd_d  = '0;
              phase_d = PH_OPSTART;
            end else if (c == smp_pkg::CH_COMMA) begin
              who_d   = smp_pkg::WHO_KEEP;
              phase_d = PH_WHO;
            end else if (c == smp_pkg::CH_NUL) begin
              emit      = 1'b1;
              emit_mode = mode_d;
            end else begin
              err_d   = 1'b1;
              phase_d = PH_ERROR;
            end
          end
        end

        default: begin
          // malformed string; also the unused phase code
          err_d   = 1'b1;
          phase_d = PH_ERROR;
          if (c == smp_pkg::CH_NUL) begin
            emit     = 1'b1;
            emit_inv = 1'b1;
          end
        end
      endcase
    end

    if (emit) begin
      phase_d = PH_START;
    end
  end

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      mode_q      <= '0;
      who_q       <= '0;
      op_q        <= OP_ADD;
      opnd_q      <= '0;
      oct_q       <= '0;
      err_q       <= 1'b0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_mode_q  <= '0;
      out_inv_q   <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        mode_q  <= mode_d;
        who_q   <= who_d;
        op_q    <= op_d;
        opnd_q  <= opnd_d;
        oct_q   <= oct_d;
        err_q   <= err_d;
        dir_q   <= dir_d;
      end
      if (accept && emit) begin
        out_valid_q <= 1'b1;
        out_mode_q  <= emit_mode;
        out_inv_q   <= emit_inv;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.new_mode = out_mode_q;
  assign out_if.invalid  = out_inv_q;

  `SMP_ASSERT_NEXT(a_nul_gives_result, clk_i, rst_ni, accept && (c == smp_pkg::CH_NUL), out_valid_q, "terminator transfer produced no result")
  `SMP_ASSERT_NEXT(a_nul_restarts, clk_i, rst_ni, accept && (c == smp_pkg::CH_NUL), phase_q == PH_START, "parser not back at string start after terminator")
  `SMP_ASSERT_NOW(a_err_phase, clk_i, rst_ni, err_q && (phase_q != PH_START), (phase_q == PH_OCTAL) || (phase_q == PH_ERROR), "error flag set in a symbolic phase")
  `SMP_ASSERT_NEXT(a_no_result_mid_string, clk_i, rst_ni, accept && (c != smp_pkg::CH_NUL) && out_if.ready, !out_valid_q, "result produced without a terminator")

endmodule

### tb/symbolic_mode_parser_tb.sv
// Self-checking bench for symbolic_mode_parser: octal and symbolic mode strings are
// streamed in a character at a time; each result is compared with a parser model kept
// in step here or a typed row. Depends on smp_pkg, smp_in_if, smp_out_if and the RTL.
`timescale 1ns / 100ps

module symbolic_mode_parser_tb;

  localparam int unsigned WATCHDOG_CYCLES = 2000;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned CHARS_PER_PHASE = 280;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned DIRECTED_ROWS   = 8;

  localparam logic [smp_pkg::CHAR_W-1:0]  CH_ZERO    = 8'h30;
  localparam logic [smp_pkg::CHAR_W-1:0]  CH_SEVEN   = 8'h37;
  localparam logic [smp_pkg::PADDR_W-1:0] UMASK_ADDR = {smp_pkg::REG_UMASK, 2'b00};

  localparam logic [smp_pkg::CHAR_W-1:0] WHO_CHARS [4] =
    '{smp_pkg::CH_U, smp_pkg::CH_G, smp_pkg::CH_O, smp_pkg::CH_A};
  localparam logic [smp_pkg::CHAR_W-1:0] OP_CHARS [3] =
    '{smp_pkg::CH_PLUS, smp_pkg::CH_MINUS, smp_pkg::CH_EQ};
  localparam logic [smp_pkg::CHAR_W-1:0] PERM_CHARS [6] =
    '{smp_pkg::CH_R, smp_pkg::CH_W, smp_pkg::CH_X, smp_pkg::CH_XU, smp_pkg::CH_S,
      smp_pkg::CH_T};

  typedef enum logic [2:0] {
    ST_IDLE, ST_OCTAL, ST_WHO, ST_OP, ST_PERMS, ST_COPIED, ST_BAD
  } parse_state_e;

  typedef enum logic [1:0] {OP_ADD, OP_DEL, OP_SET} mode_op_e;

  typedef struct packed {
    logic [smp_pkg::MODE_W-1:0] new_mode;
    logic                       invalid;
  } mode_result_t;

  typedef struct {
    string                      text;
    logic [smp_pkg::MODE_W-1:0] start;
    logic                       dir;
    bit                         typed;
    logic [smp_pkg::MODE_W-1:0] new_mode;
    logic                       invalid;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [smp_pkg::PADDR_W-1:0]  paddr;
  logic [smp_pkg::PDATA_W-1:0]  pwdata;
  logic [smp_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  smp_in_if  in_if ();
  smp_out_if out_if ();

  symbolic_mode_parser uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Parser model state
  parse_state_e               pst;
  mode_op_e                   pend_op;
  logic [smp_pkg::MODE_W-1:0] cur_mode;
  logic [smp_pkg::MODE_W-1:0] who_set;
  logic [smp_pkg::MODE_W-1:0] operand;
  logic [smp_pkg::MODE_W-1:0] oct_acc;
  logic                       oct_err;
  logic                       dir_seen;
  logic [smp_pkg::MODE_W-1:0] umask_reg;

  mode_result_t modes_due[$];
  logic [smp_pkg::CHAR_W-1:0] text_q[$];

  bit           has_typed;
  mode_result_t typed_result;
  int           fail_count;
  int           idle_cycles;
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           hold_req;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic bit is_octal(input logic [smp_pkg::CHAR_W-1:0] c);
    return c >= CH_ZERO && c <= CH_SEVEN;
  endfunction

  function automatic bit is_op(input logic [smp_pkg::CHAR_W-1:0] c);
    return c == smp_pkg::CH_PLUS || c == smp_pkg::CH_MINUS || c == smp_pkg::CH_EQ;
  endfunction

  function automatic void start_action(input logic [smp_pkg::CHAR_W-1:0] c);
    pend_op = (c == smp_pkg::CH_PLUS) ? OP_ADD : (c == smp_pkg::CH_MINUS) ? OP_DEL : OP_SET;
    operand = '0;
    pst     = ST_OP;
  endfunction

  function automatic void apply_op();
    logic [smp_pkg::MODE_W-1:0] sel;
    sel = operand & who_set;
    case (pend_op)
      OP_ADD:  cur_mode = cur_mode | sel;
      OP_DEL:  cur_mode = cur_mode & ~sel;
      default: cur_mode = (cur_mode & ~who_set) | sel;
    endcase
  endfunction

  function automatic bit close_string(output mode_result_t r,
                                      input logic [smp_pkg::MODE_W-1:0] m,
                                      input logic inv);
    r.new_mode = m;
    r.invalid  = inv;
    pst        = ST_IDLE;
    return 1'b1;
  endfunction

  // Advances the model by one character; returns 1 when a result is due.
  function automatic bit parse_mode_char(input logic [smp_pkg::CHAR_W-1:0] c,
                                         input logic [smp_pkg::MODE_W-1:0] sm,
                                         input logic dir,
                                         output mode_result_t res);
    logic [smp_pkg::MODE_W+2:0] acc;
    logic [smp_pkg::MODE_W-1:0] trio;
    int                         sh;
    bit                         perm;
    res = '0;
    if (pst == ST_IDLE) begin
      cur_mode = sm;
      dir_seen = dir;
      oct_err  = 1'b0;
      oct_acc  = '0;
      who_set  = smp_pkg::WHO_KEEP;
      pend_op  = OP_ADD;
      operand  = '0;
      if (c == smp_pkg::CH_NUL) return close_string(res, '0, 1'b1);
      if (is_octal(c)) begin
        oct_acc = smp_pkg::MODE_W'(c - CH_ZERO);
        pst     = ST_OCTAL;
        return 1'b0;
      end
      pst = ST_WHO;
    end

    if (pst == ST_OCTAL) begin
      if (c == smp_pkg::CH_NUL)
        return oct_err ? close_string(res, smp_pkg::MODE_MAX, 1'b1)
                       : close_string(res, oct_acc, 1'b0);
      if (is_octal(c)) begin
        acc = {oct_acc, 3'b000} | (smp_pkg::MODE_W+3)'(c - CH_ZERO);
        // saturates once over range and stays there
        if (oct_err || acc > (smp_pkg::MODE_W+3)'(smp_pkg::MODE_MAX)) begin
          oct_err = 1'b1;
          acc     = (smp_pkg::MODE_W+3)'(smp_pkg::MODE_MAX);
        end
        oct_acc = acc[smp_pkg::MODE_W-1:0];
      end else begin
        oct_err = 1'b1;
        pst     = ST_BAD;
      end
      return 1'b0;
    end

    if (pst == ST_WHO) begin
      case (c)
        smp_pkg::CH_U: begin who_set |= smp_pkg::WHO_U; return 1'b0; end
        smp_pkg::CH_G: begin who_set |= smp_pkg::WHO_G; return 1'b0; end
        smp_pkg::CH_O: begin who_set |= smp_pkg::WHO_O; return 1'b0; end
        smp_pkg::CH_A: begin who_set |= smp_pkg::WHO_A; return 1'b0; end
        default: ;
      endcase
      if (is_op(c)) begin
        // no who letters: all classes less the umask
        if ((who_set & smp_pkg::PERM_RWX) == '0) who_set |= smp_pkg::WHO_A & ~umask_reg;
        start_action(c);
        return 1'b0;
      end
      if (c == smp_pkg::CH_NUL) return close_string(res, '0, 1'b1);
      pst = ST_BAD;
      return 1'b0;
    end

    if (pst inside {ST_OP, ST_PERMS, ST_COPIED}) begin
      if (pst == ST_OP && (c == smp_pkg::CH_U || c == smp_pkg::CH_G || c == smp_pkg::CH_O))
      begin
        sh      = (c == smp_pkg::CH_U) ? 6 : (c == smp_pkg::CH_G) ? 3 : 0;
        trio    = (cur_mode >> sh) & 12'o7;
        operand = trio | (trio << 3) | (trio << 6);
        if ((c == smp_pkg::CH_U && cur_mode[11]) || (c == smp_pkg::CH_G && cur_mode[10]))
          operand |= smp_pkg::PERM_ID;
        who_set &= ~smp_pkg::WHO_KEEP;
        apply_op();
        pst = ST_COPIED;
        return 1'b0;
      end
      if (pst != ST_COPIED) begin
        perm = 1'b1;
        case (c)
          smp_pkg::CH_R:  operand |= smp_pkg::PERM_R;
          smp_pkg::CH_W:  operand |= smp_pkg::PERM_W;
          smp_pkg::CH_X:  operand |= smp_pkg::PERM_X;
          smp_pkg::CH_XU: if (dir_seen || (cur_mode & smp_pkg::PERM_X) != '0)
                            operand |= smp_pkg::PERM_X;
          smp_pkg::CH_S:  operand |= smp_pkg::PERM_ID;
          smp_pkg::CH_T:  ;
          default: perm = 1'b0;
        endcase
        if (perm) begin
          pst = ST_PERMS;
          return 1'b0;
        end
        apply_op();
      end
      if (is_op(c)) begin
        start_action(c);
        return 1'b0;
      end
      if (c == smp_pkg::CH_COMMA) begin
        who_set = smp_pkg::WHO_KEEP;
        pst     = ST_WHO;
        return 1'b0;
      end
      if (c == smp_pkg::CH_NUL) return close_string(res, cur_mode, 1'b0);
      pst = ST_BAD;
      return 1'b0;
    end

    // malformed: swallow everything up to the NUL
    pst = ST_BAD;
    if (c == smp_pkg::CH_NUL) return close_string(res, '0, 1'b1);
    return 1'b0;
  endfunction

  // Sampling side: model update, result check and watchdog
  always @(posedge clk_i) begin : sample_proc
    mode_result_t got;
    mode_result_t want;
    bit           moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        if (parse_mode_char(in_if.character, in_if.start_mode, in_if.is_dir, got)) begin
          if (has_typed) begin
            modes_due.push_back(typed_result);
            has_typed = 1'b0;
          end else begin
            modes_due.push_back(got);
          end
        end
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        if (modes_due.size() == 0) begin
          $error("unexpected result: new_mode=%o invalid=%b", out_if.new_mode, out_if.invalid);
          fail_count++;
        end else begin
          want = modes_due.pop_front();
          if (out_if.new_mode !== want.new_mode) begin
            $error("new_mode: expected %o, actual %o", want.new_mode, out_if.new_mode);
            fail_count++;
          end
          if (out_if.invalid !== want.invalid) begin
            $error("invalid: expected %b, actual %b", want.invalid, out_if.invalid);
            fail_count++;
          end
        end
      end
      if (psel && penable && pready) moved = 1'b1;
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side: random back-pressure plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_char(input logic [smp_pkg::CHAR_W-1:0] c,
                           input logic [smp_pkg::MODE_W-1:0] sm, input logic dir);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.character  <= c;
    in_if.start_mode <= sm;
    in_if.is_dir     <= dir;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sends text_q and its NUL; scramble gives start_mode and is_dir fresh values per byte
  task automatic send_string(input bit scramble, input logic [smp_pkg::MODE_W-1:0] sm,
                             input logic dir);
    for (int i = 0; i <= text_q.size(); i++) begin
      send_char(i < text_q.size() ? text_q[i] : smp_pkg::CH_NUL,
                scramble ? smp_pkg::MODE_W'($urandom) : sm, scramble ? 1'($urandom) : dir);
    end
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (modes_due.size() != 0);
  endtask

  task automatic apb_access(input logic wr, input logic [smp_pkg::PDATA_W-1:0] wdata,
                            output logic [smp_pkg::PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= UMASK_ADDR;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_umask(input logic [smp_pkg::MODE_W-1:0] value);
    logic [smp_pkg::PDATA_W-1:0] rd;
    apb_access(1'b1, smp_pkg::PDATA_W'(value), rd);
    umask_reg = value;
    apb_access(1'b0, '0, rd);
    if (rd[smp_pkg::MODE_W-1:0] !== value) begin
      $error("umask_bits: expected %o, actual %o", value, rd[smp_pkg::MODE_W-1:0]);
      fail_count++;
    end
  endtask

  // Mostly well-formed strings with random content, the rest octal, empty, noise or damaged
  task automatic build_random_string();
    int kind;
    int n;
    int pos;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n = $urandom_range(1, 5);
      repeat (n) text_q.push_back(smp_pkg::CHAR_W'(CH_ZERO + $urandom_range(0, 7)));
    end else if (kind < 26) begin
      // empty string below 20, raw bytes from 20 up
      if (kind >= 20) begin
        n = $urandom_range(1, 6);
        repeat (n) text_q.push_back(smp_pkg::CHAR_W'($urandom_range(1, 255)));
      end
    end else begin
      for (int k = $urandom_range(1, 3); k > 0; k--) begin
        if (text_q.size() != 0) text_q.push_back(smp_pkg::CH_COMMA);
        repeat ($urandom_range(0, 3)) text_q.push_back(WHO_CHARS[$urandom_range(0, 3)]);
        repeat ($urandom_range(1, 3)) begin
          text_q.push_back(OP_CHARS[$urandom_range(0, 2)]);
          if ($urandom_range(0, 9) < 3)
            text_q.push_back(WHO_CHARS[$urandom_range(0, 2)]);
          else
            repeat ($urandom_range(0, 4)) text_q.push_back(PERM_CHARS[$urandom_range(0, 5)]);
        end
      end
      if (kind >= 85) begin
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 3))
          0: text_q[pos] = smp_pkg::CHAR_W'($urandom_range(1, 255));
          1: text_q.insert(pos, smp_pkg::CHAR_W'($urandom_range(1, 255)));
          2: while (text_q.size() > pos) void'(text_q.pop_back());
          default: text_q.push_front(smp_pkg::CHAR_W'(CH_ZERO + $urandom_range(0, 7)));
        endcase
      end
    end
  endtask

  initial begin : stimulus
    directed_row_t              rows [DIRECTED_ROWS];
    logic [smp_pkg::MODE_W-1:0] umask_plan [PHASES];
    int                         sent;
    bit                         paused;
    bit                         held;

    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.character  <= '0;
    in_if.start_mode <= '0;
    in_if.is_dir     <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;

    pst         = ST_IDLE;
    pend_op     = OP_ADD;
    cur_mode    = '0;
    who_set     = '0;
    operand     = '0;
    oct_acc     = '0;
    oct_err     = 1'b0;
    dir_seen    = 1'b0;
    umask_reg   = '0;
    has_typed   = 1'b0;
    fail_count  = 0;
    idle_cycles = 0;
    hold_req    = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 72;

    rows = '{
      '{"",          12'o0000, 1'b0, 1'b1, 12'o0000, 1'b1},  // empty string
      '{"7777",      12'o0000, 1'b1, 1'b1, 12'o7777, 1'b0},
      '{"10000",     12'o0000, 1'b0, 1'b1, 12'o7777, 1'b1},  // octal overflow
      '{"7a",        12'o7777, 1'b0, 1'b1, 12'o0000, 1'b1},  // octal then letter
      '{"a=u",       12'o7777, 1'b0, 1'b0, 12'o0000, 1'b0},
      '{"go=u-X,+t", 12'o4755, 1'b1, 1'b0, 12'o0000, 1'b0},
      '{"a+rwxs",    12'o0000, 1'b0, 1'b0, 12'o0000, 1'b0},
      '{"ux",        12'o0644, 1'b0, 1'b1, 12'o0000, 1'b1}   // broken clause
    };
    umask_plan = '{12'o0000, 12'o7777, 12'o0022, smp_pkg::MODE_W'($urandom), 12'o0077,
                   smp_pkg::MODE_W'($urandom)};

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_for_results();
        // result register may still be draining
        repeat (4) @(negedge clk_i);
      end
      send_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 72 : 0;
      recv_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 35 : 0;
      write_umask(umask_plan[ph]);

      if (ph == 0) begin
        foreach (rows[r]) begin
          text_q.delete();
          for (int i = 0; i < rows[r].text.len(); i++) text_q.push_back(rows[r].text[i]);
          has_typed    = rows[r].typed;
          typed_result = '{new_mode: rows[r].new_mode, invalid: rows[r].invalid};
          send_string(1'b0, rows[r].start, rows[r].dir);
        end
      end

      sent   = 0;
      paused = 1'b0;
      held   = 1'b0;
      while (sent < CHARS_PER_PHASE) begin
        if ((ph == 1 || ph == 4) && !paused && sent >= CHARS_PER_PHASE / 2) begin
          paused = 1'b1;
          wait_for_results();
        end
        if (ph == 4 && !held && sent >= 100) begin
          held     = 1'b1;
          hold_req = 1'b1;
        end
        build_random_string();
        sent += text_q.size() + 1;
        send_string(1'b1, '0, 1'b0);
      end
    end

    wait_for_results();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
